>>> sv/lgs_pkg.sv
// shared types and constants for the life generation stepper
package lgs_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;
    localparam int SIZE_MIN     = 3;
    localparam int BIRTH_COUNT  = 3;
    localparam int SURVIVE_LOW  = 2;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_IN_W  = 6;
    localparam int GEN_W     = 32;
    localparam int LIVE_W    = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_SIZE_RST  = 7'd64;

    localparam logic [LIVE_W-1:0] LIVE_SAT = 13'h1FFF;
    localparam logic [GEN_W-1:0]  GEN_SAT  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_MODIFY,
        ST_PRE0,
        ST_PRE1,
        ST_PRE2,
        ST_CELL,
        ST_STORE,
        ST_NEXT,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_cmd                command;
        logic [IDX_IN_W-1:0] row;
        logic [IDX_IN_W-1:0] col;
        logic                alive_in;
    } t_in_item;

    typedef struct packed {
        logic              cell_value;
        logic [GEN_W-1:0]  generation;
        logic [LIVE_W-1:0] live_count;
        logic              stagnant;
        logic              extinct;
    } t_out_item;

endpackage

>>> sv/lgs_ram.sv
// generic simple dual-port ram with registered read
module lgs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/life_generation_stepper.sv
// Bounded Conway life grid (B3/S23) with write, read, clear and advance commands.
// The grid lives in one row-wide memory (one row per word) and every command
// except clear is done by one neighbor-count unit that visits one cell per cycle:
// write and read fetch the addressed row (write stores it back with the new cell)
// and then count the live cells, advance rebuilds each row from three row
// registers and writes it back. Clear zeroes every row of the memory. After
// reset the block runs a clearing pass over every row of the memory before it
// takes its first command. A finished result sits in an output register, so
// the next command can be taken while it waits.
module life_generation_stepper #(
    parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lgs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  lgs_pkg::t_in_item            i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output lgs_pkg::t_out_item           o_out
);

    import lgs_pkg::*;

    localparam int RA  = $clog2(MAX_ROWS);
    localparam int CA  = $clog2(MAX_COLS);
    localparam int RRW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);

    t_state r_state, n_state;

    logic [CFG_W-1:0]    r_cfg_rows, r_cfg_cols;
    logic [RRW-1:0]      r_row, n_row, r_nrows, n_nrows;
    logic [CCW-1:0]      r_col, n_col, r_ncols, n_ncols;
    logic [MAX_COLS-1:0] r_above, n_above, r_cur, n_cur;
    logic [MAX_COLS-1:0] r_below, n_below, r_new, n_new;
    t_in_item            r_item, n_item;
    logic                r_adv, n_adv, r_clr_cmd, n_clr_cmd, r_cell, n_cell;
    logic                r_changed, n_changed;
    logic [LIVE_W-1:0]   r_live, n_live;
    logic [GEN_W-1:0]    r_gen, n_gen, gen_inc;
    t_out_item           r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                ram_we;
    logic [RA-1:0]       ram_waddr, ram_raddr;
    logic [MAX_COLS-1:0] ram_wdata, ram_rdata, row_mod;

    logic [RRW-1:0]      rows_act, row_p2;
    logic [CCW-1:0]      cols_act, col_p1;
    logic [CA-1:0]       col_lo, col_m1, col_r1, item_col_idx;
    logic [RA-1:0]       item_row_addr;
    logic                item_inside, ok_l, ok_r, cur_bit, next_bit, count_bit;
    logic [3:0]          nb;

    lgs_ram #(
        .WIDTH(MAX_COLS),
        .DEPTH(MAX_ROWS)
    ) u_grid (
        .i_clk    (i_clk),
        .i_wr_en  (ram_we),
        .i_wr_addr(ram_waddr),
        .i_wr_data(ram_wdata),
        .i_rd_addr(ram_raddr),
        .o_rd_data(ram_rdata)
    );

    // active size, saturated to the legal range
    always_comb begin
        if (32'(r_cfg_rows) < SIZE_MIN) begin
            rows_act = RRW'(SIZE_MIN);
        end else if (32'(r_cfg_rows) > MAX_ROWS) begin
            rows_act = RRW'(MAX_ROWS);
        end else begin
            rows_act = RRW'(r_cfg_rows);
        end
        if (32'(r_cfg_cols) < SIZE_MIN) begin
            cols_act = CCW'(SIZE_MIN);
        end else if (32'(r_cfg_cols) > MAX_COLS) begin
            cols_act = CCW'(MAX_COLS);
        end else begin
            cols_act = CCW'(r_cfg_cols);
        end
    end

    assign item_col_idx  = CA'(r_item.col);
    assign item_row_addr = RA'(r_item.row);
    assign item_inside   = (32'(r_item.row) < 32'(r_nrows)) &&
                           (32'(r_item.col) < 32'(r_ncols));

    always_comb begin
        row_mod = ram_rdata;
        row_mod[item_col_idx] = r_item.alive_in;
    end

    // neighbor count unit, one cell per cycle
    assign col_lo  = r_col[CA-1:0];
    assign col_m1  = col_lo - CA'(1);
    assign col_r1  = col_lo + CA'(1);
    assign col_p1  = r_col + CCW'(1);
    assign ok_l    = (r_col != '0);
    assign ok_r    = (col_p1 < r_ncols);
    assign cur_bit = r_cur[col_lo];

    always_comb begin
        nb = 4'((ok_l & r_above[col_m1])) + 4'(r_above[col_lo]) + 4'((ok_r & r_above[col_r1]))
           + 4'((ok_l & r_cur[col_m1]))                         + 4'((ok_r & r_cur[col_r1]))
           + 4'((ok_l & r_below[col_m1])) + 4'(r_below[col_lo]) + 4'((ok_r & r_below[col_r1]));
    end

    assign next_bit  = (nb == 4'(BIRTH_COUNT)) | (cur_bit & (nb == 4'(SURVIVE_LOW)));
    assign count_bit = r_adv ? next_bit : cur_bit;
    assign row_p2    = r_row + RRW'(2);
    assign gen_inc   = (r_gen == GEN_SAT) ? r_gen : r_gen + GEN_W'(1);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_nrows     = r_nrows;
        n_ncols     = r_ncols;
        n_above     = r_above;
        n_cur       = r_cur;
        n_below     = r_below;
        n_new       = r_new;
        n_item      = r_item;
        n_adv       = r_adv;
        n_clr_cmd   = r_clr_cmd;
        n_cell      = r_cell;
        n_changed   = r_changed;
        n_live      = r_live;
        n_gen       = r_gen;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_row[RA-1:0];
        ram_wdata   = r_new;
        ram_raddr   = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (r_row == RRW'(MAX_ROWS - 1)) begin
                    n_live  = '0;
                    n_state = r_clr_cmd ? ST_OUT : ST_IDLE;
                end else begin
                    n_row = r_row + RRW'(1);
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item    = i_in;
                    n_nrows   = rows_act;
                    n_ncols   = cols_act;
                    n_adv     = (i_in.command == CMD_ADVANCE);
                    n_clr_cmd = (i_in.command == CMD_CLEAR);
                    n_cell    = 1'b0;
                    unique case (i_in.command)
                        CMD_CLEAR: begin
                            n_row   = '0;
                            n_state = ST_CLEAR;
                        end
                        CMD_ADVANCE: n_state = ST_PRE0;
                        CMD_WRITE,
                        CMD_READ:    n_state = ST_FETCH;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FETCH: begin
                ram_raddr = item_row_addr;
                n_state   = ST_MODIFY;
            end
            ST_MODIFY: begin
                if (item_inside && r_item.command == CMD_WRITE) begin
                    ram_we    = 1'b1;
                    ram_waddr = item_row_addr;
                    ram_wdata = row_mod;
                end
                if (item_inside && r_item.command == CMD_READ) begin
                    n_cell = ram_rdata[item_col_idx];
                end
                n_state = ST_PRE0;
            end
            ST_PRE0: begin
                ram_raddr = '0;
                n_above   = '0;
                n_row     = '0;
                n_live    = '0;
                n_changed = 1'b0;
                n_state   = ST_PRE1;
            end
            ST_PRE1: begin
                ram_raddr = RA'(1);
                n_cur     = ram_rdata;
                n_state   = ST_PRE2;
            end
            ST_PRE2: begin
                n_below = ram_rdata;
                n_new   = r_cur;
                n_col   = '0;
                n_state = ST_CELL;
            end
            ST_CELL: begin
                if (r_adv) begin
                    n_new[col_lo] = next_bit;
                    if (next_bit != cur_bit) begin
                        n_changed = 1'b1;
                    end
                end
                if (count_bit && r_live != LIVE_SAT) begin
                    n_live = r_live + LIVE_W'(1);
                end
                if (col_p1 == r_ncols) begin
                    n_state = ST_STORE;
                end else begin
                    n_col = col_p1;
                end
            end
            ST_STORE: begin
                ram_we = r_adv;
                if (r_row == r_nrows - RRW'(1)) begin
                    n_state = ST_OUT;
                end else begin
                    // slide the three-row window down by one row
                    n_above = r_cur;
                    n_cur   = r_below;
                    n_new   = r_below;
                    n_row   = r_row + RRW'(1);
                    n_col   = '0;
                    if (row_p2 < r_nrows) begin
                        ram_raddr = row_p2[RA-1:0];
                        n_state   = ST_NEXT;
                    end else begin
                        n_below = '0;
                        n_state = ST_CELL;
                    end
                end
            end
            ST_NEXT: begin
                n_below = ram_rdata;
                n_state = ST_CELL;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.cell_value = r_cell;
                    n_out.generation = r_adv ? gen_inc : r_gen;
                    n_out.live_count = r_live;
                    n_out.stagnant   = r_adv & ~r_changed;
                    n_out.extinct    = r_adv & (r_live == '0);
                    n_out_valid      = 1'b1;
                    if (r_adv) begin
                        n_gen = gen_inc;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_clr_cmd   <= 1'b0;
            r_out_valid <= 1'b0;
            r_gen       <= GEN_W'(1);
            r_cfg_rows  <= CFG_SIZE_RST;
            r_cfg_cols  <= CFG_SIZE_RST;
        end else begin
            r_row       <= n_row;
            r_clr_cmd   <= n_clr_cmd;
            r_out_valid <= n_out_valid;
            r_gen       <= n_gen;
            if (i_cfg_we && i_cfg_index == CFG_ROW_COUNT) begin
                r_cfg_rows <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_COL_COUNT) begin
                r_cfg_cols <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col     <= n_col;
        r_nrows   <= n_nrows;
        r_ncols   <= n_ncols;
        r_above   <= n_above;
        r_cur     <= n_cur;
        r_below   <= n_below;
        r_new     <= n_new;
        r_item    <= n_item;
        r_adv     <= n_adv;
        r_cell    <= n_cell;
        r_changed <= n_changed;
        r_live    <= n_live;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> sv/lgs_checker.sv
// port-level checks for the life generation stepper, bound to the top level
module lgs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input lgs_pkg::t_out_item o_out
);

    import lgs_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat dropped or changed while stalled");

    // extinct only with an empty grid
    a_extinct_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.extinct |-> o_out.live_count == '0)
        else $error("extinct reported with live cells");

    // generation starts at one and never wraps to zero
    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.generation != '0)
        else $error("generation is zero");

    // the clearing pass after reset holds off commands and results
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_in_ready && !o_out_valid)
        else $error("block active right after reset");

endmodule

bind life_generation_stepper lgs_checker u_lgs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out      (o_out)
);
